>>> hw/rtl/modexp_pkg.sv
// Shared types and constants for the modular multiply / power unit.
// Used by modexp_mulmod, modexp_dp, modexp_ctrl and modular_exponentiation_63bit.
package modexp_pkg;

  localparam int OPND_W       = 64;   // width of operand_a / operand_b
  localparam int RES_W        = 63;   // width of residue and the modulus port
  localparam int STEP_W       = $clog2(OPND_W);
  localparam int EXP_BITS_DEF = 64;
  localparam int MOD_BITS_DEF = 63;

  localparam logic [RES_W-1:0] MOD_RESET = 63'd9223372036854775783;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED_ISSUE,
    ST_RED_WAIT,
    ST_MUL_ISSUE,
    ST_MUL_WAIT,
    ST_POW_ISSUE,
    ST_POW_WAIT,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    OP_RED,
    OP_MUL,
    OP_POW
  } op_t;

  typedef struct packed {
    logic load;
    logic go;
    op_t  op;
    logic store_red;
    logic store_mul;
    logic store_pow;
    logic clear_res;
  } cmd_t;

  typedef struct packed {
    logic mod_zero;
    logic kind;
    logic done;
    logic exp_last;
  } status_t;

endpackage

>>> hw/rtl/modexp_mulmod.sv
// Bit-serial shift-and-add modular multiplier: x * y mod m, one bit of x a cycle.
// Depends on modexp_pkg.
module modexp_mulmod import modexp_pkg::*; #(
  parameter int MOD_BITS = MOD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  logic [OPND_W-1:0]   x,
  input  logic [MOD_BITS-1:0] y,
  input  logic [MOD_BITS-1:0] m,
  output logic [MOD_BITS-1:0] result,
  output logic                done
);

  logic [OPND_W-1:0]   xs;
  logic [MOD_BITS-1:0] ys;
  logic [MOD_BITS-1:0] acc;
  logic [STEP_W-1:0]   cnt;
  logic                running;

  logic [MOD_BITS:0]   dbl;
  logic [MOD_BITS:0]   m_ext;
  logic [MOD_BITS:0]   d1;
  logic [MOD_BITS:0]   sum;
  logic [MOD_BITS:0]   d2;

  // double, fold once, add the next partial product, fold once more
  always_comb begin
    m_ext = {1'b0, m};
    dbl   = {acc, 1'b0};
    d1    = (dbl >= m_ext) ? dbl - m_ext : dbl;
    sum   = d1 + (xs[OPND_W-1] ? {1'b0, ys} : '0);
    d2    = (sum >= m_ext) ? sum - m_ext : sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + STEP_W'(1);
        if (cnt == STEP_W'(OPND_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      xs  <= x;
      ys  <= y;
      acc <= '0;
    end else if (running) begin
      acc <= d2[MOD_BITS-1:0];
      xs  <= {xs[OPND_W-2:0], 1'b0};
    end
  end

  assign result = acc;

endmodule

>>> hw/rtl/modexp_dp.sv
// Datapath: modulus register, operand and exponent registers, two modular multipliers.
// Depends on modexp_pkg and modexp_mulmod.
module modexp_dp import modexp_pkg::*; #(
  parameter int EXP_BITS = EXP_BITS_DEF,
  parameter int MOD_BITS = MOD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output status_t           status,
  input  logic              modulus_wr,
  input  logic [RES_W-1:0]  modulus,
  input  logic              kind,
  input  logic [OPND_W-1:0] operand_a,
  input  logic [OPND_W-1:0] operand_b,
  output logic [RES_W-1:0]  residue
);

  localparam int CNT_W = $clog2(EXP_BITS + 1);

  logic [MOD_BITS-1:0] mod_reg;
  logic                item_kind;
  logic [OPND_W-1:0]   opa;
  logic [OPND_W-1:0]   opb;
  logic [MOD_BITS-1:0] base;
  logic [MOD_BITS-1:0] bred;
  logic [MOD_BITS-1:0] res;
  logic [CNT_W-1:0]    exp_cnt;

  logic [OPND_W-1:0]   x0, x1;
  logic [MOD_BITS-1:0] y0, y1;
  logic [MOD_BITS-1:0] r0, r1;
  logic                done0, done1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mod_reg <= MOD_RESET[MOD_BITS-1:0];
    end else if (modulus_wr) begin
      mod_reg <= modulus[MOD_BITS-1:0];
    end
  end

  // unit 0 multiplies, unit 1 squares; both reduce operands on entry
  always_comb begin
    case (cmd.op)
      OP_RED: begin
        x0 = opa;
        y0 = MOD_BITS'(1);
        x1 = opb;
        y1 = MOD_BITS'(1);
      end
      OP_MUL: begin
        x0 = OPND_W'(base);
        y0 = bred;
        x1 = OPND_W'(base);
        y1 = base;
      end
      OP_POW: begin
        x0 = OPND_W'(res);
        y0 = base;
        x1 = OPND_W'(base);
        y1 = base;
      end
      default: begin
        x0 = opa;
        y0 = MOD_BITS'(1);
        x1 = opb;
        y1 = MOD_BITS'(1);
      end
    endcase
  end

  modexp_mulmod #(.MOD_BITS(MOD_BITS)) u_mul (
    .clk(clk), .rst(rst), .go(cmd.go), .x(x0), .y(y0), .m(mod_reg),
    .result(r0), .done(done0)
  );

  modexp_mulmod #(.MOD_BITS(MOD_BITS)) u_sqr (
    .clk(clk), .rst(rst), .go(cmd.go), .x(x1), .y(y1), .m(mod_reg),
    .result(r1), .done(done1)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_kind <= kind;
      opa       <= operand_a;
      opb       <= operand_b;
    end
    if (cmd.store_red) begin
      base    <= r0;
      bred    <= r1;
      res     <= (mod_reg == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
      exp_cnt <= CNT_W'(EXP_BITS);
    end
    if (cmd.store_mul) begin
      res <= r0;
    end
    if (cmd.store_pow) begin
      base    <= r1;
      if (opb[0]) begin
        res <= r0;
      end
      opb     <= {1'b0, opb[OPND_W-1:1]};
      exp_cnt <= exp_cnt - CNT_W'(1);
    end
    if (cmd.clear_res) begin
      res <= '0;
    end
  end

  always_comb begin
    status.mod_zero = (mod_reg == '0);
    status.kind     = item_kind;
    status.done     = done0 & done1;
    status.exp_last = (exp_cnt == CNT_W'(1));
  end

  assign residue = RES_W'(res);

endmodule

>>> hw/rtl/modexp_ctrl.sv
// Controller: sequences reduction, multiply and the square-and-multiply loop.
// Depends on modexp_pkg.
module modexp_ctrl import modexp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy,
  output logic    done
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_RED_ISSUE;
      end
      ST_RED_ISSUE: begin
        state_next = status.mod_zero ? ST_FINISH : ST_RED_WAIT;
      end
      ST_RED_WAIT: begin
        if (status.done) state_next = status.kind ? ST_POW_ISSUE : ST_MUL_ISSUE;
      end
      ST_MUL_ISSUE: state_next = ST_MUL_WAIT;
      ST_MUL_WAIT: begin
        if (status.done) state_next = ST_FINISH;
      end
      ST_POW_ISSUE: state_next = ST_POW_WAIT;
      ST_POW_WAIT: begin
        if (status.done) state_next = status.exp_last ? ST_FINISH : ST_POW_ISSUE;
      end
      ST_FINISH: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_RED_ISSUE: begin
        cmd.op        = OP_RED;
        cmd.go        = ~status.mod_zero;
        cmd.clear_res = status.mod_zero;
      end
      ST_RED_WAIT: begin
        cmd.op        = OP_RED;
        cmd.store_red = status.done;
      end
      ST_MUL_ISSUE: begin
        cmd.op = OP_MUL;
        cmd.go = 1'b1;
      end
      ST_MUL_WAIT: begin
        cmd.op        = OP_MUL;
        cmd.store_mul = status.done;
      end
      ST_POW_ISSUE: begin
        cmd.op = OP_POW;
        cmd.go = 1'b1;
      end
      ST_POW_WAIT: begin
        cmd.op        = OP_POW;
        cmd.store_pow = status.done;
      end
      ST_FINISH: done = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

>>> hw/rtl/modular_exponentiation_63bit.sv
// Modular multiply (a*b mod m) and power (a^b mod m, right-to-left square and multiply).
// One item at a time; each modular product step issues both bit-serial multipliers over the
// 64 bits of x and waits for their done. A multiply is a reduction and one product step, a
// power a reduction and one step per exponent bit; a zero modulus ends with residue 0, no step.
// busy drops the cycle after done; start is taken only in idle. The receiver cannot stall.
// Synchronous reset returns to idle with the modulus at 9223372036854775783.
module modular_exponentiation_63bit import modexp_pkg::*; #(
  parameter int EXP_BITS = EXP_BITS_DEF,
  parameter int MOD_BITS = MOD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              kind,
  input  logic [OPND_W-1:0] operand_a,
  input  logic [OPND_W-1:0] operand_b,
  input  logic              modulus_wr,
  input  logic [RES_W-1:0]  modulus,
  output logic              done,
  output logic [RES_W-1:0]  residue
);

  cmd_t    cmd;
  status_t status;

  modexp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .status(status), .cmd(cmd),
    .busy(busy), .done(done)
  );

  modexp_dp #(.EXP_BITS(EXP_BITS), .MOD_BITS(MOD_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .modulus_wr(modulus_wr), .modulus(modulus),
    .kind(kind), .operand_a(operand_a), .operand_b(operand_b),
    .residue(residue)
  );

endmodule
